FILE: rtl/core/vtpc_pkg.sv
// vtpc_pkg: shared types, constants and helpers for the vertex transform pipeline
// no dependencies
package vtpc_pkg;

  // quotient magnitude bits kept by the divider, one bit per stage
  localparam int unsigned QBits = 17;
  localparam int unsigned RemBits = 23;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_X_COEF  = 3'd0,
    CFG_Y_COEF  = 3'd1,
    CFG_Z_COEF  = 3'd2,
    CFG_TRANS   = 3'd3,
    CFG_ZOOM    = 3'd4,
    CFG_BOUNDS  = 3'd5,
    CFG_OFFSETS = 3'd6,
    CFG_MODE    = 3'd7
  } cfg_idx_e;

  localparam logic [4:0] CodeBehind = 5'b10000;

  // configuration as seen by the pipeline
  typedef struct packed {
    logic [53:0] x_coef;
    logic [53:0] y_coef;
    logic [53:0] z_coef;
    logic [59:0] trans;
    logic [23:0] zoom;
    logic [63:0] bounds;
    logic [31:0] offsets;
    logic        mode;
  } cfg_t;

  // eye-space word
  typedef struct packed {
    logic signed [23:0] ex;
    logic signed [23:0] ey;
    logic signed [23:0] ez;
    logic               last;
  } eye_t;

  // word travelling through the divider stages
  typedef struct packed {
    eye_t                 eye;
    logic [3:0]           code;
    logic                 behind;
    logic                 sign_h;
    logic                 sign_v;
    logic                 ovf_h;
    logic                 ovf_v;
    logic [RemBits-1:0]   dvs;
    logic [RemBits-1:0]   rem_h;
    logic [RemBits-1:0]   rem_v;
    logic [QBits-1:0]     low_h;
    logic [QBits-1:0]     low_v;
    logic [QBits-1:0]     q_h;
    logic [QBits-1:0]     q_v;
  } div_t;

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    logic signed [25:0] hi;
    logic signed [25:0] lo;
    hi = 26'sd8388607;
    lo = -26'sd8388608;
    if (v > hi) sat24 = 24'sd8388607;
    else if (v < lo) sat24 = -24'sd8388608;
    else sat24 = v[23:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [18:0] hi;
    logic signed [18:0] lo;
    hi = 19'sd32767;
    lo = -19'sd32768;
    if (v > hi) sat16 = 16'sd32767;
    else if (v < lo) sat16 = -16'sd32768;
    else sat16 = v[15:0];
  endfunction

endpackage

FILE: rtl/core/vtpc_eye.sv
// vtpc_eye: three-stage rotate and translate of one point into eye space
// depends on vtpc_pkg
module vtpc_eye (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  vtpc_pkg::cfg_t     cfg_i,
  input  logic               valid_i,
  input  logic signed [19:0] point_x_i,
  input  logic signed [19:0] point_y_i,
  input  logic signed [19:0] point_z_i,
  input  logic               last_i,
  output logic               valid_o,
  output vtpc_pkg::eye_t     eye_o
);
  import vtpc_pkg::*;

  logic signed [19:0] pt    [3];
  logic signed [19:0] tr    [3];
  logic signed [17:0] cf    [3][3];
  logic signed [20:0] v_d   [3];
  logic signed [20:0] v_q   [3];
  logic signed [38:0] prd_d [3][3];
  logic signed [38:0] prd_q [3][3];
  logic signed [23:0] eye_d [3];
  logic               valid1_q, valid2_q, valid3_q;
  logic               last1_q, last2_q;
  eye_t               eye_q;

  // unpack fields
  always_comb begin
    pt[0] = point_x_i;
    pt[1] = point_y_i;
    pt[2] = point_z_i;
    for (int i = 0; i < 3; i++) begin
      tr[i]    = $signed(cfg_i.trans[20*i +: 20]);
      cf[0][i] = $signed(cfg_i.x_coef[18*i +: 18]);
      cf[1][i] = $signed(cfg_i.y_coef[18*i +: 18]);
      cf[2][i] = $signed(cfg_i.z_coef[18*i +: 18]);
    end
  end

  // stage 1: optional pre-translation
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cfg_i.mode) v_d[i] = 21'(pt[i]) - 21'(tr[i]);
      else v_d[i] = 21'(pt[i]);
    end
  end

  // stage 2: nine matrix products, prd[j][i] is input j into eye i
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        prd_d[j][i] = 39'(cf[j][i]) * 39'(v_q[j]);
      end
    end
  end

  // stage 3: sum, round half up, post-translation when mode is clear, saturate
  always_comb begin
    logic signed [40:0] acc;
    logic signed [25:0] r;
    for (int i = 0; i < 3; i++) begin
      acc = 41'(prd_q[0][i]) + 41'(prd_q[1][i]) + 41'(prd_q[2][i]) + 41'sd32768;
      r = 26'($signed(acc[40:16]));
      if (!cfg_i.mode) r = r + 26'(tr[i]);
      eye_d[i] = sat24(r);
    end
  end

  // pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q      <= v_d;
      last1_q  <= last_i;
      prd_q    <= prd_d;
      last2_q  <= last1_q;
      eye_q.ex <= eye_d[0];
      eye_q.ey <= eye_d[1];
      eye_q.ez <= eye_d[2];
      eye_q.last <= last2_q;
    end
  end

  assign valid_o = valid3_q;
  assign eye_o   = eye_q;

endmodule

FILE: rtl/core/vtpc_proj_setup.sv
// vtpc_proj_setup: projection products, outcode compares and divider set-up
// depends on vtpc_pkg
module vtpc_proj_setup (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  vtpc_pkg::cfg_t cfg_i,
  input  logic           valid_i,
  input  vtpc_pkg::eye_t eye_i,
  output logic           valid_o,
  output vtpc_pkg::div_t div_o
);
  import vtpc_pkg::*;

  logic signed [48:0] mh_d, mv_d, mh_q, mv_q;
  logic signed [39:0] b_d [4];
  logic signed [39:0] b_q [4];
  logic signed [15:0] bnd [4];
  eye_t               eye_q;
  logic               valid4_q, valid5_q;
  div_t               div_d, div_q;

  always_comb begin
    for (int k = 0; k < 4; k++) bnd[k] = $signed(cfg_i.bounds[16*k +: 16]);
  end

  // stage 4: zoom products and bound times depth
  always_comb begin
    mh_d = 49'($signed({1'b0, cfg_i.zoom})) * 49'(eye_i.ey);
    mv_d = 49'($signed({1'b0, cfg_i.zoom})) * 49'(eye_i.ez);
    for (int k = 0; k < 4; k++) b_d[k] = 40'(bnd[k]) * 40'(eye_i.ex);
  end

  // stage 5: negate, compare against bounds, magnitude and overflow check
  always_comb begin
    logic signed [49:0] nh, nv, mgh, mgv;
    logic signed [49:0] bb [4];
    logic [39:0]        ah, av;
    nh = -50'(mh_q);
    nv = -50'(mv_q);
    for (int k = 0; k < 4; k++) bb[k] = 50'($signed({b_q[k], 8'b0}));
    mgh = nh[49] ? -nh : nh;
    mgv = nv[49] ? -nv : nv;
    ah = mgh[47:8];
    av = mgv[47:8];
    div_d.eye    = eye_q;
    div_d.behind = eye_q.ex[23] || (eye_q.ex == 24'sd0);
    div_d.code[0] = nh > bb[0];
    div_d.code[1] = !(nh > bb[0]) && (nh < bb[1]);
    div_d.code[2] = nv > bb[2];
    div_d.code[3] = !(nv > bb[2]) && (nv < bb[3]);
    div_d.sign_h = nh[49];
    div_d.sign_v = nv[49];
    div_d.dvs    = eye_q.ex[RemBits-1:0];
    div_d.rem_h  = ah[39:QBits];
    div_d.rem_v  = av[39:QBits];
    div_d.ovf_h  = ah[39:QBits] >= eye_q.ex[RemBits-1:0];
    div_d.ovf_v  = av[39:QBits] >= eye_q.ex[RemBits-1:0];
    div_d.low_h  = ah[QBits-1:0];
    div_d.low_v  = av[QBits-1:0];
    div_d.q_h    = '0;
    div_d.q_v    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid4_q <= 1'b0;
      valid5_q <= 1'b0;
    end else if (en_i) begin
      valid4_q <= valid_i;
      valid5_q <= valid4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mh_q  <= mh_d;
      mv_q  <= mv_d;
      b_q   <= b_d;
      eye_q <= eye_i;
      div_q <= div_d;
    end
  end

  assign valid_o = valid5_q;
  assign div_o   = div_q;

endmodule

FILE: rtl/core/vtpc_div_stage.sv
// vtpc_div_stage: one restoring division step for both screen axes
// depends on vtpc_pkg
module vtpc_div_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  vtpc_pkg::div_t div_i,
  output logic           valid_o,
  output vtpc_pkg::div_t div_o
);
  import vtpc_pkg::*;

  div_t div_d, div_q;
  logic valid_q;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    logic [RemBits:0] th, tv;
    logic             gh, gv;
    th = {div_i.rem_h, div_i.low_h[QBits-1]};
    tv = {div_i.rem_v, div_i.low_v[QBits-1]};
    gh = th >= {1'b0, div_i.dvs};
    gv = tv >= {1'b0, div_i.dvs};
    div_d = div_i;
    div_d.rem_h = gh ? RemBits'(th - {1'b0, div_i.dvs}) : th[RemBits-1:0];
    div_d.rem_v = gv ? RemBits'(tv - {1'b0, div_i.dvs}) : tv[RemBits-1:0];
    div_d.low_h = {div_i.low_h[QBits-2:0], 1'b0};
    div_d.low_v = {div_i.low_v[QBits-2:0], 1'b0};
    div_d.q_h   = {div_i.q_h[QBits-2:0], gh};
    div_d.q_v   = {div_i.q_v[QBits-2:0], gv};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (en_i) valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) div_q <= div_d;
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

FILE: rtl/core/vertex_transform_project_clip.sv
// Throughput: one word per cycle; the whole pipeline advances while the
// output register is empty or its word is taken, one divider stage per quotient bit.
// Reset: asynchronous active low, clears valid bits and restores configuration register defaults.
// Holds the configuration registers, the pipeline chain and the output register.
// Depends on vtpc_pkg, vtpc_eye, vtpc_proj_setup and vtpc_div_stage.
module vertex_transform_project_clip (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [19:0] point_x_i,
  input  logic signed [19:0] point_y_i,
  input  logic signed [19:0] point_z_i,
  input  logic               last_point_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [23:0] eye_x_o,
  output logic signed [23:0] eye_y_o,
  output logic signed [23:0] eye_z_o,
  output logic signed [15:0] screen_h_o,
  output logic signed [15:0] screen_v_o,
  output logic [4:0]         clip_code_o,
  output logic               last_result_o
);
  import vtpc_pkg::*;

  cfg_t cfg_q;
  logic en;
  logic eye_valid;
  eye_t eye_w;
  logic div_valid [QBits+1];
  div_t div_w     [QBits+1];
  logic out_valid_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_coef  <= 54'd65536;
      cfg_q.y_coef  <= 54'd17179869184;
      cfg_q.z_coef  <= 54'd4503599627370496;
      cfg_q.trans   <= '0;
      cfg_q.zoom    <= 24'd65536;
      cfg_q.bounds  <= '0;
      cfg_q.offsets <= '0;
      cfg_q.mode    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_X_COEF:  cfg_q.x_coef  <= cfg_data_i[53:0];
        CFG_Y_COEF:  cfg_q.y_coef  <= cfg_data_i[53:0];
        CFG_Z_COEF:  cfg_q.z_coef  <= cfg_data_i[53:0];
        CFG_TRANS:   cfg_q.trans   <= cfg_data_i[59:0];
        CFG_ZOOM:    cfg_q.zoom    <= cfg_data_i[23:0];
        CFG_BOUNDS:  cfg_q.bounds  <= cfg_data_i;
        CFG_OFFSETS: cfg_q.offsets <= cfg_data_i[31:0];
        CFG_MODE:    cfg_q.mode    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // pipeline advance
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  vtpc_eye u_eye (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .cfg_i     (cfg_q),
    .valid_i   (in_valid_i),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .point_z_i (point_z_i),
    .last_i    (last_point_i),
    .valid_o   (eye_valid),
    .eye_o     (eye_w)
  );

  vtpc_proj_setup u_setup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (eye_valid),
    .eye_i   (eye_w),
    .valid_o (div_valid[0]),
    .div_o   (div_w[0])
  );

  // divider chain
  for (genvar s = 0; s < QBits; s++) begin : g_div
    vtpc_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_valid[s]),
      .div_i   (div_w[s]),
      .valid_o (div_valid[s+1]),
      .div_o   (div_w[s+1])
    );
  end

  // output stage: sign, clamp, offset
  logic signed [15:0] sh_d, sv_d;
  always_comb begin
    logic signed [QBits:0] qh, qv;
    logic [QBits-1:0]      mh, mv;
    mh = div_w[QBits].ovf_h ? '1 : div_w[QBits].q_h;
    mv = div_w[QBits].ovf_v ? '1 : div_w[QBits].q_v;
    qh = div_w[QBits].sign_h ? -$signed({1'b0, mh}) : $signed({1'b0, mh});
    qv = div_w[QBits].sign_v ? -$signed({1'b0, mv}) : $signed({1'b0, mv});
    sh_d = sat16(19'(qh) + 19'($signed(cfg_q.offsets[15:0])));
    sv_d = sat16(19'(qv) + 19'($signed(cfg_q.offsets[31:16])));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= div_valid[QBits];
  end

  // output register, behind handling
  always_ff @(posedge clk_i) begin
    if (en) begin
      eye_x_o       <= div_w[QBits].eye.ex;
      eye_y_o       <= div_w[QBits].eye.ey;
      eye_z_o       <= div_w[QBits].eye.ez;
      last_result_o <= div_w[QBits].eye.last;
      if (div_w[QBits].behind) begin
        screen_h_o  <= '0;
        screen_v_o  <= '0;
        clip_code_o <= CodeBehind;
      end else begin
        screen_h_o  <= sh_d;
        screen_v_o  <= sv_d;
        clip_code_o <= {1'b0, div_w[QBits].code};
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/vtpc_checker.sv
// vtpc_checker: port-level assertions for the vertex transform pipeline
// depends on vtpc_pkg; bound to vertex_transform_project_clip
module vtpc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [23:0] eye_x_o,
  input logic signed [15:0] screen_h_o,
  input logic signed [15:0] screen_v_o,
  input logic [4:0]         clip_code_o
);
  import vtpc_pkg::*;

  // a stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(eye_x_o) && $stable(clip_code_o))
    else $error("stalled result word changed");

  // behind the viewer: no screen position and only the behind bit
  a_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (eye_x_o[23] || eye_x_o == 24'sd0) |->
      clip_code_o == CodeBehind && screen_h_o == 16'sd0 && screen_v_o == 16'sd0)
    else $error("behind point not flagged");

  // in front: behind bit clear
  a_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !eye_x_o[23] && eye_x_o != 24'sd0 |-> !clip_code_o[4])
    else $error("front point flagged behind");

  // min and max edge bits are exclusive on each axis
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(clip_code_o[0] && clip_code_o[1]) && !(clip_code_o[2] && clip_code_o[3]))
    else $error("both edge bits set");

endmodule

bind vertex_transform_project_clip vtpc_checker u_vtpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .eye_x_o     (eye_x_o),
  .screen_h_o  (screen_h_o),
  .screen_v_o  (screen_v_o),
  .clip_code_o (clip_code_o)
);

FILE: tb/testbench.sv
// testbench for vertex_transform_project_clip: a directed table, then random points
// under several register settings, checked against an in-bench transform and projection
// depends on vtpc_pkg and the vertex_transform_project_clip rtl
module testbench;
  import vtpc_pkg::*;

  typedef struct {
    logic signed [23:0] ex;
    logic signed [23:0] ey;
    logic signed [23:0] ez;
    logic signed [15:0] sh;
    logic signed [15:0] sv;
    logic [4:0]         code;
    logic               last;
  } vertex_res_t;

  typedef struct {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
    logic               last;
    bit                 typed;
    vertex_res_t        want;
  } point_row_t;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 30;
  localparam int unsigned NumPhases = 10;
  localparam int unsigned PointsPerPhase = 165;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [63:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [19:0] point_x_i;
  logic signed [19:0] point_y_i;
  logic signed [19:0] point_z_i;
  logic               last_point_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [23:0] eye_x_o;
  logic signed [23:0] eye_y_o;
  logic signed [23:0] eye_z_o;
  logic signed [15:0] screen_h_o;
  logic signed [15:0] screen_v_o;
  logic [4:0]         clip_code_o;
  logic               last_result_o;

  cfg_t        shadow_cfg;
  vertex_res_t pending_vertices[$];
  point_row_t  directed_points[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          no_idle;

  vertex_transform_project_clip u_dut (.*);

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic longint clamp_to(input longint v, input int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // rotate, translate, project and form the outcode for one point
  function automatic vertex_res_t project_vertex(input logic signed [19:0] px,
                                                 input logic signed [19:0] py,
                                                 input logic signed [19:0] pz,
                                                 input logic last);
    longint      pt[3];
    longint      tr[3];
    longint      vv[3];
    longint      eye[3];
    longint      acc;
    longint      den;
    longint      nh;
    longint      nv;
    longint      lim[4];
    vertex_res_t r;
    pt[0] = px;
    pt[1] = py;
    pt[2] = pz;
    for (int i = 0; i < 3; i++) begin
      tr[i] = longint'($signed(shadow_cfg.trans[20*i +: 20]));
      vv[i] = shadow_cfg.mode ? pt[i] - tr[i] : pt[i];
    end
    for (int i = 0; i < 3; i++) begin
      acc = longint'($signed(shadow_cfg.x_coef[18*i +: 18])) * vv[0]
          + longint'($signed(shadow_cfg.y_coef[18*i +: 18])) * vv[1]
          + longint'($signed(shadow_cfg.z_coef[18*i +: 18])) * vv[2];
      acc = (acc + 32768) >>> 16;
      if (!shadow_cfg.mode) acc += tr[i];
      eye[i] = clamp_to(acc, 24);
    end
    r.ex = 24'(eye[0]);
    r.ey = 24'(eye[1]);
    r.ez = 24'(eye[2]);
    r.last = last;
    r.sh = '0;
    r.sv = '0;
    if (eye[0] > 0) begin
      for (int k = 0; k < 4; k++) lim[k] = longint'($signed(shadow_cfg.bounds[16*k +: 16]));
      den = 256 * eye[0];
      nh = -(longint'(shadow_cfg.zoom) * eye[1]);
      nv = -(longint'(shadow_cfg.zoom) * eye[2]);
      r.sh = 16'(clamp_to(nh / den + longint'($signed(shadow_cfg.offsets[15:0])), 16));
      r.sv = 16'(clamp_to(nv / den + longint'($signed(shadow_cfg.offsets[31:16])), 16));
      r.code = '0;
      // outcode from the exact ratio, max bound tested first
      if (nh > lim[0] * den) r.code[0] = 1'b1;
      else if (nh < lim[1] * den) r.code[1] = 1'b1;
      if (nv > lim[2] * den) r.code[2] = 1'b1;
      else if (nv < lim[3] * den) r.code[3] = 1'b1;
    end else begin
      r.code = CodeBehind;
    end
    return r;
  endfunction

  function automatic int unsigned gap_length();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 19);
    if (roll < 12) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [19:0] rand_coord();
    if ($urandom_range(0, 4) == 0) return 20'($signed($urandom_range(0, 8191)) - 4096);
    return 20'($urandom);
  endfunction

  function automatic logic [17:0] rand_term();
    if ($urandom_range(0, 2) == 0) return 18'($urandom);
    return 18'($signed($urandom_range(0, 131071)) - 65536);
  endfunction

  function automatic logic [15:0] rand_bound();
    if ($urandom_range(0, 2) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 1023)) - 512);
  endfunction

  task automatic add_point(input logic signed [19:0] x, input logic signed [19:0] y,
                           input logic signed [19:0] z, input logic last, input bit typed,
                           input logic signed [23:0] ex, input logic [4:0] code);
    point_row_t row;
    row.x = x;
    row.y = y;
    row.z = z;
    row.last = last;
    row.typed = typed;
    row.want.ex = ex;
    row.want.ey = y;
    row.want.ez = z;
    row.want.sh = '0;
    row.want.sv = '0;
    row.want.code = code;
    row.want.last = last;
    directed_points.push_back(row);
  endtask

  // one register word over the configuration channel
  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_X_COEF:  shadow_cfg.x_coef = data[53:0];
      CFG_Y_COEF:  shadow_cfg.y_coef = data[53:0];
      CFG_Z_COEF:  shadow_cfg.z_coef = data[53:0];
      CFG_TRANS:   shadow_cfg.trans = data[59:0];
      CFG_ZOOM:    shadow_cfg.zoom = data[23:0];
      CFG_BOUNDS:  shadow_cfg.bounds = data;
      CFG_OFFSETS: shadow_cfg.offsets = data[31:0];
      CFG_MODE:    shadow_cfg.mode = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // one point word; valid stays high into the next word when there is no gap
  task automatic send_point(input point_row_t row);
    int unsigned gap;
    gap = gap_length();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    point_x_i = row.x;
    point_y_i = row.y;
    point_z_i = row.z;
    last_point_i = row.last;
    do @(posedge clk_i); while (!in_ready_o);
    pending_vertices.push_back(row.typed ? row.want
                               : project_vertex(row.x, row.y, row.z, row.last));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    point_row_t row;
    logic [63:0] data;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_X_COEF;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    point_x_i = '0;
    point_y_i = '0;
    point_z_i = '0;
    last_point_i = 1'b0;
    mismatches = 0;
    no_idle = 1'b0;
    shadow_cfg.x_coef = 54'd65536;
    shadow_cfg.y_coef = 54'd1 << 34;
    shadow_cfg.z_coef = 54'd1 << 52;
    shadow_cfg.trans = '0;
    shadow_cfg.zoom = 24'd65536;
    shadow_cfg.bounds = '0;
    shadow_cfg.offsets = '0;
    shadow_cfg.mode = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table under reset registers: identity, no translation
    add_point(20'sd0, 20'sd0, 20'sd0, 1'b0, 1'b1, 24'sd0, CodeBehind);
    add_point(-20'sd524288, 20'sd524287, -20'sd524288, 1'b0, 1'b1, -24'sd524288, CodeBehind);
    add_point(20'sd524287, 20'sd0, 20'sd0, 1'b1, 1'b1, 24'sd524287, 5'd0);
    add_point(20'sd524287, 20'sd524287, -20'sd524288, 1'b0, 1'b0, '0, '0);
    add_point(20'sd1, 20'sd524287, 20'sd524287, 1'b0, 1'b0, '0, '0);
    add_point(20'sd1, -20'sd524288, -20'sd524288, 1'b1, 1'b0, '0, '0);
    add_point(20'sd256, -20'sd1, 20'sd1, 1'b0, 1'b0, '0, '0);
    add_point(20'sd256, 20'sd256, -20'sd256, 1'b0, 1'b0, '0, '0);
    add_point(-20'sd1, 20'sd12345, 20'sd777, 1'b1, 1'b0, '0, '0);
    add_point(20'sd4096, -20'sd8192, 20'sd8192, 1'b0, 1'b0, '0, '0);
    @(negedge clk_i);
    foreach (directed_points[i]) send_point(directed_points[i]);

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        drain();
        for (int r = 0; r < 8; r++) begin
          case (ph)
            1: data = '1;
            2: data = '0;
            default: begin
              data = {$urandom, $urandom};
              if (r < 3) data[53:0] = {rand_term(), rand_term(), rand_term()};
              if (r == 3) data[59:0] = {rand_coord(), rand_coord(), rand_coord()};
              if (r == 5) data = {rand_bound(), rand_bound(), rand_bound(), rand_bound()};
              if (r == 7) data[0] = ph[0];
            end
          endcase
          write_reg(cfg_idx_e'(r), data);
        end
      end
      no_idle = (ph == 4);
      for (int n = 0; n < PointsPerPhase; n++) begin
        row.x = rand_coord();
        row.y = rand_coord();
        row.z = rand_coord();
        row.last = 1'($urandom);
        row.typed = 1'b0;
        send_point(row);
      end
    end
    drain();

    if (mismatches == 0) $display("PASS vertex_transform_project_clip");
    else $display("FAIL vertex_transform_project_clip");
    $finish;
  end

  // result side back-pressure
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        stall--;
      end else begin
        out_ready_i = 1'b1;
        stall = gap_length();
      end
    end
  end

  // compare each taken result word with the oldest expectation
  always @(posedge clk_i) begin
    vertex_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_vertices.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
      end else begin
        want = pending_vertices.pop_front();
        if (eye_x_o !== want.ex) begin
          $error("eye_x expected %0d got %0d", want.ex, eye_x_o);
          mismatches++;
        end
        if (eye_y_o !== want.ey) begin
          $error("eye_y expected %0d got %0d", want.ey, eye_y_o);
          mismatches++;
        end
        if (eye_z_o !== want.ez) begin
          $error("eye_z expected %0d got %0d", want.ez, eye_z_o);
          mismatches++;
        end
        if (screen_h_o !== want.sh) begin
          $error("screen_h expected %0d got %0d", want.sh, screen_h_o);
          mismatches++;
        end
        if (screen_v_o !== want.sv) begin
          $error("screen_v expected %0d got %0d", want.sv, screen_v_o);
          mismatches++;
        end
        if (clip_code_o !== want.code) begin
          $error("clip_code expected %0d got %0d", want.code, clip_code_o);
          mismatches++;
        end
        if (last_result_o !== want.last) begin
          $error("last_result expected %0d got %0d", want.last, last_result_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL vertex_transform_project_clip");
      $finish;
    end
  end

endmodule

FILE: sim.f
rtl/core/vtpc_pkg.sv
rtl/core/vtpc_eye.sv
rtl/core/vtpc_proj_setup.sv
rtl/core/vtpc_div_stage.sv
rtl/core/vertex_transform_project_clip.sv
rtl/core/vtpc_checker.sv
tb/testbench.sv
